FILE: hdl/ales_pkg.sv
package ales_pkg;

   // Default count of all-zero latch words after a frame's last pixel
   localparam int LATCH_WORDS_DEFAULT = 6;

   // Control register indexes
   localparam logic [1:0] CSR_BRIGHTNESS = 2'd0;
   localparam logic [1:0] CSR_ONE_CODE   = 2'd1;
   localparam logic [1:0] CSR_ZERO_CODE  = 2'd2;

   // Control register reset values and the brightness limit
   localparam logic [6:0] BRIGHTNESS_RESET = 7'd100;
   localparam logic [6:0] BRIGHTNESS_MAX   = 7'd100;
   localparam logic [7:0] ONE_CODE_RESET   = 8'hF8;
   localparam logic [7:0] ZERO_CODE_RESET  = 8'hC0;

   // Word slots of one pixel, in transmit order
   localparam int WORD_GREEN = 0;
   localparam int WORD_RED   = 1;
   localparam int WORD_BLUE  = 2;
   localparam int DATA_WORDS = 3;

   // Rounding and divide by 100: floor(x * 20972 / 2^21) is exact for x < 43690
   localparam logic [14:0] ROUND_BIAS = 15'd50;
   localparam logic [14:0] DIV_RECIP  = 15'd20972;
   localparam int          DIV_SHIFT  = 21;
   localparam logic [8:0]  CHAN_MAX   = 9'd255;

   // Control that travels with each word through the pipeline
   typedef struct packed {
      logic valid;
      logic is_data;
      logic last_word;
   } word_tag_type;

   // Expand a byte into eight SPI code bytes, MSB first in bits 63..56
   function automatic logic [63:0] encode_byte(
      input logic [7:0] value,
      input logic [7:0] one_code,
      input logic [7:0] zero_code
   );
      logic [63:0] word;
      word = '0;
      for (int b = 0; b < 8; b++) begin
         word[b*8 +: 8] = value[b] ? one_code : zero_code;
      end
      return word;
   endfunction

endpackage

FILE: hdl/addressable_led_spi_encoder.sv
// Encodes RGB pixels for WS2812B-style LEDs driven from an SPI data line. Each accepted pixel
// gives three 64-bit words (green, red, blue), one per cycle while rsp_stall is low; each
// channel is scaled by the brightness register with rounding and each data bit becomes one SPI
// code byte, first byte in bits 63..56. A pixel flagged last_pixel is followed by LATCH_WORDS
// zero words, the final one marked by rsp_last_word. The word sequencer emits these words one
// word a cycle while the output is not stalled; the next pixel is taken as the previous one's
// final word moves on. The first word of a pixel passes the sequencer's pixel registers, the
// scale register and the output register, in that order, before it appears.
// Write the control registers only while no frame is in flight.
module addressable_led_spi_encoder #(
   parameter int LATCH_WORDS = ales_pkg::LATCH_WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_last_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_spi_word,
   output logic        rsp_last_word,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic                   advance;
   logic [6:0]             brightness_ff;
   logic [7:0]             one_code_ff;
   logic [7:0]             zero_code_ff;
   logic [7:0]             chan_value;
   logic [14:0]            prod;
   ales_pkg::word_tag_type seq_tag;
   ales_pkg::word_tag_type scale_tag;

   // Move the whole pipeline when the output word is free or taken
   assign advance = !rsp_valid || !rsp_stall;

   // Control registers; brightness clamps at 100
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= ales_pkg::BRIGHTNESS_RESET;
         one_code_ff   <= ales_pkg::ONE_CODE_RESET;
         zero_code_ff  <= ales_pkg::ZERO_CODE_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            ales_pkg::CSR_BRIGHTNESS:
               brightness_ff <= (csr_wdata[6:0] > ales_pkg::BRIGHTNESS_MAX) ?
                                ales_pkg::BRIGHTNESS_MAX : csr_wdata[6:0];
            ales_pkg::CSR_ONE_CODE:  one_code_ff  <= csr_wdata;
            ales_pkg::CSR_ZERO_CODE: zero_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ales_seq #(
      .LATCH_WORDS(LATCH_WORDS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .chan_value     (chan_value),
      .tag            (seq_tag)
   );

   ales_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .chan_value (chan_value),
      .brightness (brightness_ff),
      .tag_in     (seq_tag),
      .prod       (prod),
      .tag        (scale_tag)
   );

   ales_encode u_encode (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .prod          (prod),
      .tag_in        (scale_tag),
      .one_code      (one_code_ff),
      .zero_code     (zero_code_ff),
      .rsp_valid     (rsp_valid),
      .rsp_spi_word  (rsp_spi_word),
      .rsp_last_word (rsp_last_word)
   );

   // Brightness never leaves its legal range
   a_bright_range: assert property (@(posedge clock) disable iff (reset)
      brightness_ff <= ales_pkg::BRIGHTNESS_MAX)
      else $error("brightness above 100");

   // The frame-end word is a latch word
   a_last_is_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_word |-> rsp_spi_word == 64'd0)
      else $error("last word carries data");

   // A scaled channel waiting behind a stalled output holds
   a_scale_hold: assert property (@(posedge clock) disable iff (reset)
      scale_tag.valid && !advance |=> $stable(prod) && $stable(scale_tag))
      else $error("scale stage changed under stall");

   // A latch word in the scale register comes out as an all-zero word
   a_latch_no_data: assert property (@(posedge clock) disable iff (reset)
      scale_tag.valid && !scale_tag.is_data && advance |=> rsp_spi_word == 64'd0)
      else $error("latch word not zero");

endmodule

FILE: hdl/ales_seq.sv
module ales_seq #(
   parameter int LATCH_WORDS = ales_pkg::LATCH_WORDS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,
   input  logic                     req_last_pixel,
   output logic [7:0]               chan_value,
   output ales_pkg::word_tag_type   tag
);

   localparam int IDX_W = $clog2(ales_pkg::DATA_WORDS + LATCH_WORDS);
   localparam logic [IDX_W-1:0] LAST_DATA_IDX  = IDX_W'(ales_pkg::WORD_BLUE);
   localparam logic [IDX_W-1:0] LAST_LATCH_IDX =
      IDX_W'(ales_pkg::DATA_WORDS + LATCH_WORDS - 1);

   logic             busy_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [7:0]       red_ff, green_ff, blue_ff;
   logic             last_pixel_ff;
   logic             final_word;
   logic             accept;

   // The word in flight is the pixel's last one
   assign final_word = busy_ff &&
      ((idx_ff == LAST_DATA_IDX && !last_pixel_ff) || idx_ff == LAST_LATCH_IDX);

   // Take a new pixel when empty or when the last word moves on
   assign req_stall = busy_ff && !(advance && final_word);
   assign accept    = req_valid && !req_stall;

   // Hold the pixel and step through its words
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (advance && busy_ff) begin
         if (final_word) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff        <= req_red;
         green_ff      <= req_green;
         blue_ff       <= req_blue;
         last_pixel_ff <= req_last_pixel;
      end
   end

   // Pick the channel for the current word
   always_comb begin
      case (idx_ff)
         IDX_W'(ales_pkg::WORD_GREEN): chan_value = green_ff;
         IDX_W'(ales_pkg::WORD_RED):   chan_value = red_ff;
         IDX_W'(ales_pkg::WORD_BLUE):  chan_value = blue_ff;
         default:                      chan_value = 8'd0;
      endcase
   end

   always_comb begin
      tag.valid     = busy_ff;
      tag.is_data   = idx_ff <= LAST_DATA_IDX;
      tag.last_word = idx_ff == LAST_LATCH_IDX;
   end

endmodule

FILE: hdl/ales_scale.sv
module ales_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [7:0]               chan_value,
   input  logic [6:0]               brightness,
   input  ales_pkg::word_tag_type   tag_in,
   output logic [14:0]              prod,
   output ales_pkg::word_tag_type   tag
);

   ales_pkg::word_tag_type tag_ff;
   logic [14:0]            prod_ff;
   logic [14:0]            prod_in;

   // Scale with rounding bias: v * p + 50
   assign prod_in = 15'(chan_value * brightness) + ales_pkg::ROUND_BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
   assign tag  = tag_ff;

endmodule

FILE: hdl/ales_encode.sv
module ales_encode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [14:0]              prod,
   input  ales_pkg::word_tag_type   tag_in,
   input  logic [7:0]               one_code,
   input  logic [7:0]               zero_code,
   output logic                     rsp_valid,
   output logic [63:0]              rsp_spi_word,
   output logic                     rsp_last_word
);

   logic [29:0] recip_prod;
   logic [8:0]  quot;
   logic [7:0]  scaled;
   logic        valid_ff;
   logic [63:0] spi_word_ff, spi_word_in;
   logic        last_word_ff;

   // Divide by 100 through the reciprocal, then saturate
   assign recip_prod = prod * ales_pkg::DIV_RECIP;
   assign quot       = recip_prod[ales_pkg::DIV_SHIFT +: 9];
   assign scaled     = (quot > ales_pkg::CHAN_MAX) ? 8'hFF : quot[7:0];

   // Data words carry the code bytes, latch words are zero
   assign spi_word_in = tag_in.is_data ?
      ales_pkg::encode_byte(scaled, one_code, zero_code) : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= tag_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         spi_word_ff  <= spi_word_in;
         last_word_ff <= tag_in.last_word && !tag_in.is_data;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_spi_word  = spi_word_ff;
   assign rsp_last_word = last_word_ff;

endmodule

FILE: dv/addressable_led_spi_encoder_tb.sv
`timescale 1ns / 100ps

module addressable_led_spi_encoder_tb;

   // Index that decodes to no register
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int LATCH_COUNT = ales_pkg::LATCH_WORDS_DEFAULT;

   typedef struct {
      logic [63:0] spi_word;
      logic        last_word;
   } led_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic        req_last_pixel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_spi_word;
   logic        rsp_last_word;
   logic        csr_wen;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   // Shadow copy of the control registers
   logic [6:0] shade_pct;
   logic [7:0] mark_byte;
   logic [7:0] space_byte;

   led_word_type pending_words[$];
   int send_gap_pct;
   int rsp_hold_pct;
   int fail_count;
   int pixels_taken;
   int frame_count;
   int word_count;
   int setting_count;

   addressable_led_spi_encoder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_spi_word   (rsp_spi_word),
      .rsp_last_word  (rsp_last_word),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Scale one channel by the brightness percent, rounding half up
   function automatic logic [7:0] dim_level(input logic [7:0] level);
      int unsigned scaled;
      scaled = (int'(level) * int'(shade_pct) + 50) / 100;
      if (scaled > 255) begin
         scaled = 255;
      end
      return scaled[7:0];
   endfunction

   // Turn each data bit into one SPI code byte, MSB first in the top byte
   function automatic logic [63:0] spread_bits(input logic [7:0] level);
      logic [63:0] word;
      word = '0;
      for (int b = 7; b >= 0; b--) begin
         word = {word[55:0], level[b] ? mark_byte : space_byte};
      end
      return word;
   endfunction

   // Queue the words one pixel produces: G, R, B, then the latch if last
   task automatic encode_pixel(input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue, input logic last_pixel);
      led_word_type w;
      w.last_word = 1'b0;
      w.spi_word = spread_bits(dim_level(green));
      pending_words.push_back(w);
      w.spi_word = spread_bits(dim_level(red));
      pending_words.push_back(w);
      w.spi_word = spread_bits(dim_level(blue));
      pending_words.push_back(w);
      if (last_pixel) begin
         for (int k = 0; k < LATCH_COUNT; k++) begin
            w.spi_word = '0;
            w.last_word = (k == LATCH_COUNT - 1);
            pending_words.push_back(w);
         end
         frame_count++;
      end
   endtask

   // Offer one pixel, with random idle cycles ahead of it, and hold until taken
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic last_pixel);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         req_red = 8'($urandom);
         req_green = 8'($urandom);
         req_blue = 8'($urandom);
         req_last_pixel = 1'($urandom);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_red = red;
      req_green = green;
      req_blue = blue;
      req_last_pixel = last_pixel;
      forever begin
         @(posedge clock);
         if (!req_stall) begin
            break;
         end
      end
      encode_pixel(red, green, blue, last_pixel);
      pixels_taken++;
   endtask

   // Stop sending and wait until every expected word has come out
   task automatic drain_words();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Write one control register while the pipe is empty
   task automatic write_register(input logic [1:0] index, input logic [7:0] data);
      drain_words();
      @(negedge clock);
      csr_wen = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      case (index)
         ales_pkg::CSR_BRIGHTNESS: begin
            shade_pct = (data[6:0] > ales_pkg::BRIGHTNESS_MAX) ?
                        ales_pkg::BRIGHTNESS_MAX : data[6:0];
         end
         ales_pkg::CSR_ONE_CODE: begin
            mark_byte = data;
         end
         ales_pkg::CSR_ZERO_CODE: begin
            space_byte = data;
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_wen = 1'b0;
      setting_count++;
   endtask

   // Stall the result side at random
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < rsp_hold_pct);
      end
   end

   // Compare each accepted word with the oldest expected one
   initial begin
      led_word_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               $error("unexpected word: spi_word %h last_word %b", rsp_spi_word,
                      rsp_last_word);
               fail_count++;
            end else begin
               want = pending_words.pop_front();
               word_count++;
               if (rsp_spi_word !== want.spi_word) begin
                  $error("spi_word mismatch: expected %h, got %h", want.spi_word,
                         rsp_spi_word);
                  fail_count++;
               end
               if (rsp_last_word !== want.last_word) begin
                  $error("last_word mismatch: expected %b, got %b", want.last_word,
                         rsp_last_word);
                  fail_count++;
               end
            end
         end
      end
   end

   // Bound the run
   initial begin
      #5000000;
      $display("timeout with %0d words outstanding", pending_words.size());
      $display("FAIL addressable_led_spi_encoder");
      $finish;
   end

   // Default registers straight out of reset
   task automatic test_reset_defaults();
      send_pixel(8'hFF, 8'h00, 8'hA5, 1'b0);
      send_pixel(8'h01, 8'h80, 8'h7F, 1'b1);
   endtask

   // Channel extremes and alternating bit patterns, with and without the latch
   task automatic test_channel_extremes();
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
      send_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
   endtask

   // Brightness: zero, rounding edges, full scale and clamping of large writes
   task automatic test_brightness();
      write_register(ales_pkg::CSR_BRIGHTNESS, 8'd0);
      send_pixel(8'hFF, 8'h80, 8'h01, 1'b0);
      write_register(ales_pkg::CSR_BRIGHTNESS, 8'd50);
      send_pixel(8'd1, 8'd3, 8'd255, 1'b0);
      write_register(ales_pkg::CSR_BRIGHTNESS, 8'd49);
      send_pixel(8'd1, 8'd3, 8'd255, 1'b0);
      write_register(ales_pkg::CSR_BRIGHTNESS, 8'd1);
      send_pixel(8'd49, 8'd50, 8'd255, 1'b1);
      write_register(ales_pkg::CSR_BRIGHTNESS, 8'd99);
      send_pixel(8'd50, 8'd51, 8'd255, 1'b0);
      write_register(ales_pkg::CSR_BRIGHTNESS, 8'd101);
      send_pixel(8'd200, 8'd255, 8'd17, 1'b0);
      write_register(ales_pkg::CSR_BRIGHTNESS, 8'd127);
      send_pixel(8'd255, 8'd128, 8'd0, 1'b1);
      // top bit of the write data lies outside the register
      write_register(ales_pkg::CSR_BRIGHTNESS, 8'hA8);
      send_pixel(8'd100, 8'd255, 8'd3, 1'b0);
      write_register(ales_pkg::CSR_BRIGHTNESS, {1'b0, ales_pkg::BRIGHTNESS_RESET});
   endtask

   // Code byte patterns, and a write to an unused index that must change nothing
   task automatic test_code_bytes();
      write_register(ales_pkg::CSR_ONE_CODE, 8'hFF);
      write_register(ales_pkg::CSR_ZERO_CODE, 8'h00);
      send_pixel(8'hC3, 8'h3C, 8'h81, 1'b0);
      write_register(ales_pkg::CSR_ONE_CODE, 8'h00);
      write_register(ales_pkg::CSR_ZERO_CODE, 8'hFF);
      send_pixel(8'hC3, 8'h3C, 8'h81, 1'b1);
      write_register(CSR_UNUSED, 8'h5A);
      send_pixel(8'h0F, 8'hF0, 8'h99, 1'b0);
      write_register(ales_pkg::CSR_ONE_CODE, ales_pkg::ONE_CODE_RESET);
      write_register(ales_pkg::CSR_ZERO_CODE, ales_pkg::ZERO_CODE_RESET);
   endtask

   // Pick a fresh register setting, often an extreme
   task automatic pick_setting();
      logic [7:0] pct;
      logic [7:0] one_code;
      logic [7:0] zero_code;
      case ($urandom_range(5))
         0: pct = 8'd0;
         1: pct = 8'd100;
         2: pct = 8'($urandom_range(101, 255));
         default: pct = 8'($urandom_range(1, 99));
      endcase
      one_code = ($urandom_range(3) == 0) ? {8{$urandom_range(1) == 1}} : 8'($urandom);
      zero_code = ($urandom_range(3) == 0) ? {8{$urandom_range(1) == 1}} : 8'($urandom);
      write_register(ales_pkg::CSR_BRIGHTNESS, pct);
      write_register(ales_pkg::CSR_ONE_CODE, one_code);
      write_register(ales_pkg::CSR_ZERO_CODE, zero_code);
      if ($urandom_range(3) == 0) begin
         write_register(CSR_UNUSED, 8'($urandom));
      end
   endtask

   // Random frames of a few pixels each; now and then a stray last flag
   task automatic test_random_frames(input int pixels);
      int sent;
      int frame_len;
      logic last_pixel;
      sent = 0;
      while (sent < pixels) begin
         frame_len = $urandom_range(1, 6);
         for (int k = 0; k < frame_len && sent < pixels; k++) begin
            last_pixel = (k == frame_len - 1);
            if ($urandom_range(9) == 0) begin
               last_pixel = 1'($urandom);
            end
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), last_pixel);
            sent++;
         end
      end
   endtask

   // Three pressure phases, each with several register settings
   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 28;
               rsp_hold_pct = 87;
            end
            1: begin
               send_gap_pct = 87;
               rsp_hold_pct = 28;
            end
            default: begin
               send_gap_pct = 0;
               rsp_hold_pct = 0;
            end
         endcase
         for (int chunk = 0; chunk < 3; chunk++) begin
            pick_setting();
            test_random_frames(17);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_red = '0;
      req_green = '0;
      req_blue = '0;
      req_last_pixel = 1'b0;
      csr_wen = 1'b0;
      csr_index = ales_pkg::CSR_BRIGHTNESS;
      csr_wdata = '0;
      shade_pct = ales_pkg::BRIGHTNESS_RESET;
      mark_byte = ales_pkg::ONE_CODE_RESET;
      space_byte = ales_pkg::ZERO_CODE_RESET;
      send_gap_pct = 20;
      rsp_hold_pct = 30;
      fail_count = 0;
      pixels_taken = 0;
      frame_count = 0;
      word_count = 0;
      setting_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_channel_extremes();
      test_brightness();
      test_code_bytes();
      test_random_traffic();

      // Let the last words out, then a few quiet cycles
      drain_words();
      repeat (10) @(posedge clock);
      $display("covered %0d pixels in %0d frames, %0d words checked", pixels_taken,
               frame_count, word_count);
      $display("%0d register writes, brightness 0..100 with clamping, code extremes",
               setting_count);
      if (fail_count == 0) begin
         $display("PASS addressable_led_spi_encoder");
      end else begin
         $display("FAIL addressable_led_spi_encoder");
      end
      $finish;
   end

endmodule
